// ----- rtl/core/pbg_pkg.sv -----
// pbg_pkg: shared constants, command and status types and the output mix
// function of the pcg32 bounded generator; depends on nothing
`timescale 1ns / 1ps

package pbg_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;

    localparam logic [STATE_W-1:0] PCG_MULT = 64'h5851F42D4C957F2D;
    localparam logic [WORD_W-1:0]  MULT_LO  = PCG_MULT[31:0];
    localparam logic [WORD_W-1:0]  MULT_HI  = PCG_MULT[63:32];

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_div;
        logic div_sel_value;
        logic save_limit;
        logic start_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_done;
        logic div_done;
        logic is_draw;
        logic bound_zero;
        logic reject;
    } ctrl_sts_t;

    // xsh-rr output taken from the old state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0] x;
        logic [WORD_W-1:0]  mixed;
        logic [5:0]         rot;
        x     = ((old >> 18) ^ old) >> 27;
        mixed = x[WORD_W-1:0];
        rot   = {1'b0, old[63:59]};
        return (mixed >> rot) | (mixed << (6'd32 - rot));
    endfunction

endpackage

// ----- rtl/core/pbg_req_if.sv -----
// pbg_req_if: request channel carrying a command word (reseed or draw)
// depends on pbg_pkg for field widths
`timescale 1ns / 1ps

interface pbg_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [pbg_pkg::STATE_W-1:0]  seed_state;
    logic [pbg_pkg::STATE_W-1:0]  seed_sequence;
    logic [pbg_pkg::WORD_W-1:0]   bound;

    modport source (output valid, output cmd, output seed_state, output seed_sequence,
                    output bound, input ready);
    modport sink   (input valid, input cmd, input seed_state, input seed_sequence,
                    input bound, output ready);
endinterface

// ----- rtl/core/pbg_rsp_if.sv -----
// pbg_rsp_if: result channel carrying one value word per request
// depends on pbg_pkg for field widths
`timescale 1ns / 1ps

interface pbg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pbg_pkg::WORD_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/core/pbg_divider.sv -----
// pbg_divider: bit-serial restoring remainder unit, one bit per cycle
// depends on pbg_pkg for the word width
`timescale 1ns / 1ps

module pbg_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pbg_pkg::WORD_W-1:0] dividend,
    input  logic [pbg_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [pbg_pkg::WORD_W-1:0] remainder
);

    localparam int unsigned W  = pbg_pkg::WORD_W;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvd_reg;
    logic [W-1:0]  dsr_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[W-1:0];
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/pbg_datapath.sv -----
// pbg_datapath: generator state, split 64-bit multiply step, rejection limit,
// remainder unit and result register; depends on pbg_pkg and pbg_divider
`timescale 1ns / 1ps

module pbg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_cmd,
    input  logic [pbg_pkg::STATE_W-1:0] in_seed_state,
    input  logic [pbg_pkg::STATE_W-1:0] in_seed_sequence,
    input  logic [pbg_pkg::WORD_W-1:0]  in_bound,
    input  pbg_pkg::ctrl_cmd_t          cmd,
    output pbg_pkg::ctrl_sts_t          sts,
    output logic [pbg_pkg::WORD_W-1:0]  value
);

    localparam int unsigned SW = pbg_pkg::STATE_W;
    localparam int unsigned WW = pbg_pkg::WORD_W;

    logic [SW-1:0] state_reg;
    logic [SW-1:0] inc_reg;
    logic [SW-1:0] inc_next;
    logic          active_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    mul_sel;

    logic          cmd_reg;
    logic [WW-1:0] bound_reg;
    logic [WW-1:0] rnd_reg;
    logic [WW-1:0] limit_reg;
    logic [WW-1:0] value_reg;
    logic [SW-1:0] prod_reg;
    logic [SW-1:0] acc_reg;

    logic [WW-1:0] mul_a;
    logic [WW-1:0] mul_b;
    logic [SW-1:0] prod_next;

    logic [WW-1:0] div_dividend;
    logic          div_done;
    logic [WW-1:0] div_rem;

    assign inc_next = {in_seed_sequence[SW-2:0], 1'b1};
    assign mul_sel  = cmd.start_step ? 2'd0 : phase_reg;

    // partial products of state * multiplier, only the low 64 bits are kept
    always_comb
    begin
        case (mul_sel)
            2'd1:
            begin
                mul_a = state_reg[WW-1:0];
                mul_b = pbg_pkg::MULT_HI;
            end
            2'd2:
            begin
                mul_a = state_reg[SW-1:WW];
                mul_b = pbg_pkg::MULT_LO;
            end
            default:
            begin
                mul_a = state_reg[WW-1:0];
                mul_b = pbg_pkg::MULT_LO;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            inc_reg    <= SW'(1);
            active_reg <= 1'b0;
            phase_reg  <= 2'd0;
        end
        else
        begin
            if (cmd.load_item && !in_cmd)
            begin
                // stepping from a zero state just yields the increment
                inc_reg   <= inc_next;
                state_reg <= inc_next + in_seed_state;
            end
            else if (active_reg && phase_reg == 2'd3)
            begin
                state_reg <= acc_reg + {prod_reg[WW-1:0], {WW{1'b0}}};
            end
            if (cmd.start_step)
            begin
                active_reg <= 1'b1;
                phase_reg  <= 2'd1;
            end
            else if (active_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_item)
        begin
            cmd_reg   <= in_cmd;
            bound_reg <= in_bound;
        end
        if (cmd.start_step)
        begin
            rnd_reg <= pbg_pkg::xsh_rr(state_reg);
        end
        if (active_reg && phase_reg == 2'd1)
        begin
            acc_reg <= prod_reg + inc_reg;
        end
        else if (active_reg && phase_reg == 2'd2)
        begin
            acc_reg <= acc_reg + {prod_reg[WW-1:0], {WW{1'b0}}};
        end
        if (cmd.save_limit)
        begin
            limit_reg <= div_rem;
        end
        if (cmd.load_out)
        begin
            if (!cmd_reg || bound_reg == '0)
            begin
                value_reg <= '0;
            end
            else
            begin
                value_reg <= div_rem;
            end
        end
    end

    // (2^32 - n) mod n, then the accepted output mod n
    assign div_dividend = cmd.div_sel_value ? rnd_reg : (WW'(0) - bound_reg);

    pbg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (div_dividend),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign sts.step_done  = active_reg && (phase_reg == 2'd3);
    assign sts.div_done   = div_done;
    assign sts.is_draw    = cmd_reg;
    assign sts.bound_zero = (bound_reg == '0);
    assign sts.reject     = (rnd_reg < limit_reg);
    assign value          = value_reg;

endmodule

// ----- rtl/core/pbg_controller.sv -----
// pbg_controller: one-hot sequencer for reseed and bounded draw words
// depends on pbg_pkg for the command and status types
`timescale 1ns / 1ps

module pbg_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  pbg_pkg::ctrl_sts_t sts,
    output pbg_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_LIMIT    = 7'b0000100,
        S_STEP     = 7'b0001000,
        S_CHECK    = 7'b0010000,
        S_MODV     = 7'b0100000,
        S_FINISH   = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!sts.is_draw)
                begin
                    cmd.start_step = 1'b1;
                    state_next     = S_STEP;
                end
                else if (sts.bound_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                if (sts.div_done)
                begin
                    cmd.save_limit = 1'b1;
                    cmd.start_step = 1'b1;
                    state_next     = S_STEP;
                end
            end
            S_STEP:
            begin
                if (sts.step_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.is_draw)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.reject)
                begin
                    cmd.start_step = 1'b1;
                    state_next     = S_STEP;
                end
                else
                begin
                    cmd.start_div     = 1'b1;
                    cmd.div_sel_value = 1'b1;
                    state_next        = S_MODV;
                end
            end
            S_MODV:
            begin
                cmd.div_sel_value = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/pcg32_bounded_generator_unit.sv -----
// pcg32 xsh-rr generator with unbiased bounded draws, one word at a time.
// time from request to result depends on the command: a reseed takes one multiply
// step, a draw with zero bound goes straight to the result, and another draw takes
// two passes of the bit-serial remainder unit and a step with its check per try.
// a new request is taken the cycle after its result reaches the output register.
// async active-low reset: state 0, increment 1, no result pending.
`timescale 1ns / 1ps

module pcg32_bounded_generator_unit (
    input  logic      clk,
    input  logic      rst_n,
    pbg_req_if.sink   req,
    pbg_rsp_if.source rsp
);

    pbg_pkg::ctrl_cmd_t cmd;
    pbg_pkg::ctrl_sts_t sts;

    pbg_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pbg_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_cmd           (req.cmd),
        .in_seed_state    (req.seed_state),
        .in_seed_sequence (req.seed_sequence),
        .in_bound         (req.bound),
        .cmd              (cmd),
        .sts              (sts),
        .value            (rsp.value)
    );

endmodule

// ----- tb/sv/pcg32_bounded_generator_unit_tb.sv -----
// pcg32_bounded_generator_unit_tb: self-checking bench for the pcg32 bounded generator.
// Drives reseed and draw words through a queue-fed driver and checks each value word
// against a local generator model; depends on pbg_pkg, pbg_req_if, pbg_rsp_if and the rtl
`timescale 1ns / 1ps

module pcg32_bounded_generator_unit_tb;
    import pbg_pkg::*;

    localparam int unsigned QUIET_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 200;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_WORDS     = 180;

    typedef enum logic {
        CMD_RESEED = 1'b0,
        CMD_DRAW   = 1'b1
    } gen_cmd_e;

    typedef struct packed {
        gen_cmd_e           cmd;
        logic [STATE_W-1:0] seed_state;
        logic [STATE_W-1:0] seed_sequence;
        logic [WORD_W-1:0]  bound;
    } gen_word_t;

    logic clk;
    logic rst_n;

    pbg_req_if req_ch ();
    pbg_rsp_if rsp_ch ();

    pcg32_bounded_generator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    gen_word_t          pending_words[$];
    logic [WORD_W-1:0]  expected_values[$];
    logic [STATE_W-1:0] gen_state     = '0;
    logic [STATE_W-1:0] gen_increment = 64'd1;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        stall_cycles;
    int unsigned        quiet_cycles;
    int unsigned        mismatch_count;
    logic               req_fire;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // xsh-rr permutation of the pre-step state
    function automatic logic [WORD_W-1:0] xsh_rr_word(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0]  shifted;
        logic [WORD_W-1:0]   folded;
        logic [2*WORD_W-1:0] doubled;
        shifted = ((old >> 18) ^ old) >> 27;
        folded  = shifted[WORD_W-1:0];
        // rotate right by shifting a doubled copy
        doubled = {folded, folded} >> old[63:59];
        return doubled[WORD_W-1:0];
    endfunction

    task automatic step_generator(output logic [WORD_W-1:0] word);
        word      = xsh_rr_word(gen_state);
        gen_state = gen_state * PCG_MULT + gen_increment;
    endtask

    task automatic predict_value(input gen_word_t w, output logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] limit;
        value = '0;
        if (w.cmd == CMD_RESEED)
        begin
            gen_increment = {w.seed_sequence[STATE_W-2:0], 1'b1};
            gen_state     = '0;
            step_generator(raw);
            gen_state = gen_state + w.seed_state;
            step_generator(raw);
        end
        else if (w.bound != '0)
        begin
            // (2^32 - n) mod n is just (-n) mod n in 32 bits
            limit = (-w.bound) % w.bound;
            do
                step_generator(raw);
            while (raw < limit);
            value = raw % w.bound;
        end
    endtask

    task automatic queue_word(input gen_cmd_e cmd, input logic [STATE_W-1:0] seed_state,
                              input logic [STATE_W-1:0] seed_sequence,
                              input logic [WORD_W-1:0] bound);
        gen_word_t w;
        w.cmd           = cmd;
        w.seed_state    = seed_state;
        w.seed_sequence = seed_sequence;
        w.bound         = bound;
        pending_words.push_back(w);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned count);
        logic [WORD_W-1:0] bound;
        gen_cmd_e          cmd;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
        begin
            cmd = ($urandom_range(99) < 8) ? CMD_RESEED : CMD_DRAW;
            case ($urandom_range(9))
                0:       bound = '0;
                1:       bound = $urandom_range(16, 1);
                2:       bound = 32'h8000_0000 + $urandom_range(255, 1);
                3:       bound = 32'hFFFF_FFFF - $urandom_range(15, 0);
                default: bound = $urandom;
            endcase
            queue_word(cmd, {$urandom, $urandom}, {$urandom, $urandom}, bound);
        end
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // request driver, fed from the pending queue
    always @(negedge clk)
    begin : word_driver
        gen_word_t w;
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.cmd           <= w.cmd;
                req_ch.seed_state    <= w.seed_state;
                req_ch.seed_sequence <= w.seed_sequence;
                req_ch.bound         <= w.bound;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= (stall_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted down here
    always @(negedge clk)
    begin
        if (stall_cycles != 0)
            stall_cycles <= stall_cycles - 1;
    end

    always @(posedge clk)
    begin : word_monitor
        gen_word_t         seen;
        logic [WORD_W-1:0] predicted;
        logic [WORD_W-1:0] want;
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.cmd           = gen_cmd_e'(req_ch.cmd);
                seen.seed_state    = req_ch.seed_state;
                seen.seed_sequence = req_ch.seed_sequence;
                seen.bound         = req_ch.bound;
                predict_value(seen, predicted);
                expected_values.push_back(predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("value word with nothing expected: actual %h", rsp_ch.value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (rsp_ch.value !== want)
                    begin
                        $error("value mismatch: expected %h, actual %h", want, rsp_ch.value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = 1'b0;
        req_ch.seed_state    = '0;
        req_ch.seed_sequence = '0;
        req_ch.bound         = '0;
        rsp_ch.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        stall_cycles         = 0;
        quiet_cycles         = 0;
        mismatch_count       = 0;
        req_fire             = 1'b0;

        // draws straight out of reset use increment 1
        queue_word(CMD_DRAW,   '0, '0, 32'd10);
        queue_word(CMD_DRAW,   '0, '0, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd1);
        queue_word(CMD_DRAW,   '0, '0, 32'hFFFF_FFFF);
        // bound is ignored on a reseed
        queue_word(CMD_RESEED, '0, '0, 32'hFFFF_FFFF);
        // worst-case rejection rate just above half range
        queue_word(CMD_DRAW,   '0, '0, 32'h8000_0001);
        queue_word(CMD_DRAW,   '0, '0, 32'h8000_0000);
        queue_word(CMD_DRAW,   '0, '0, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd2);
        queue_word(CMD_RESEED, '1, '1, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd3);
        // seed fields ignored on a draw
        queue_word(CMD_DRAW,   '1, '1, 32'h7FFF_FFFF);
        queue_word(CMD_RESEED, 64'd42, 64'd54, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd6);
        // top bit of the stream selector falls off the increment
        queue_word(CMD_RESEED, 64'd42, 64'd54 | 64'h8000_0000_0000_0000, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd6);
        queue_word(CMD_DRAW,   '0, '0, 32'hC000_0001);
        queue_word(CMD_RESEED, '1, '0, 32'd5);
        queue_word(CMD_DRAW,   '0, '0, 32'hAAAA_AAAA);
        queue_word(CMD_DRAW,   '0, '0, 32'h5555_5555);
        queue_word(CMD_DRAW,   '0, '0, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd0);
        queue_word(CMD_DRAW,   '0, '0, 32'd7);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);

        run_phase(0, 0, PHASE_WORDS);
        run_phase(55, 0, PHASE_WORDS);
        run_phase(0, 55, PHASE_WORDS);
        run_phase(15, 15, PHASE_WORDS);

        // hold the result side off while words keep coming
        stall_cycles = HOLD_OFF_CYCLES;
        run_phase(0, 0, 12);

        while (pending_words.size() != 0 || req_ch.valid || expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_values.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pbg_pkg.sv
rtl/core/pbg_req_if.sv
rtl/core/pbg_rsp_if.sv
rtl/core/pbg_divider.sv
rtl/core/pbg_datapath.sv
rtl/core/pbg_controller.sv
rtl/core/pcg32_bounded_generator_unit.sv
tb/sv/pcg32_bounded_generator_unit_tb.sv
